[rtl/tvta_pkg.sv]
// Shared types, constants and step functions for the thrust vector to tilt angles pipeline.
package tvta_pkg;

  localparam int ROTORS_DEF   = 4;
  localparam int STAGES_DEF   = 16;
  localparam int ATAN_LEN     = 24;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 17;
  localparam int CFG_REGS     = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;
  localparam int ELEV_W       = 11;
  localparam int CW           = 35;   // CORDIC x/y width
  localparam int AW           = 32;   // angle accumulator width, pi = 2^30
  localparam int EW           = 31;   // clamped elevation angle width
  localparam int PROD_W       = 41;
  localparam int NUM_W        = 28;
  localparam int MaxDeciDeg   = 1800; // 180 degrees in tenths

  localparam logic [ELEV_W-1:0] ELEV_RESET = 11'd900;
  localparam logic signed [AW-1:0] PI_UNITS = 32'sd1073741824;

  localparam logic signed [AW-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'sd268435456, 32'sd158466703, 32'sd83729454, 32'sd42502378,
    32'sd21333666,  32'sd10677233,  32'sd5339919,  32'sd2670123,
    32'sd1335082,   32'sd667543,    32'sd333772,   32'sd166886,
    32'sd83443,     32'sd41722,     32'sd20861,    32'sd10430,
    32'sd5215,      32'sd2608,      32'sd1304,     32'sd652,
    32'sd326,       32'sd163,       32'sd81,       32'sd41
  };

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_lane_t;

  typedef struct packed {
    sq_lane_t           m;   // magnitude root of x^2+y^2+z^2
    sq_lane_t           r;   // root of (x^2+y^2) * 2^32
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [1:0]         idx;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 hold;  // vector on the x axis, angle already final
  } cl_t;

  typedef struct packed {
    cl_t         az;
    cl_t         el;
    logic [15:0] mag;
    logic [1:0]  idx;
  } cd_t;

  typedef struct packed {
    logic [ELEV_W-1:0] rem;
    logic [16:0]       low;
    logic [16:0]       quo;
    logic [ELEV_W-1:0] m;
    logic              sat;
    logic [15:0]       az;
    logic [15:0]       mag;
    logic [1:0]        idx;
  } dv_t;

  // One digit of the square root: bring down two radicand bits, try the subtraction.
  function automatic sq_lane_t sq_step(sq_lane_t l);
    logic [35:0] cur;
    logic [35:0] trial;
    sq_lane_t    r;
    cur   = {l.rem, l.rad[63:62]};
    trial = {2'b00, l.root, 2'b01};
    if (cur >= trial) begin
      r.rem  = 34'(cur - trial);
      r.root = {l.root[30:0], 1'b1};
    end else begin
      r.rem  = cur[33:0];
      r.root = {l.root[30:0], 1'b0};
    end
    r.rad = {l.rad[61:0], 2'b00};
    return r;
  endfunction

  // Fold the vector into the right half plane and seed the angle.
  function automatic cl_t cl_pre(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    cl_t r;
    r.x    = x;
    r.y    = y;
    r.hold = (y == '0);
    r.acc  = '0;
    if (y == '0) begin
      r.acc = x[CW-1] ? PI_UNITS : '0;
    end else if (x[CW-1]) begin
      r.acc = y[CW-1] ? -PI_UNITS : PI_UNITS;
      r.x   = -x;
      r.y   = -y;
    end
    return r;
  endfunction

  // One vectoring rotation toward y = 0.
  function automatic cl_t cl_step(cl_t l, int unsigned sh, logic signed [AW-1:0] ang);
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    cl_t                  r;
    r  = l;
    xs = l.x >>> sh;
    ys = l.y >>> sh;
    if (!l.hold) begin
      if (!l.y[CW-1]) begin
        r.x   = l.x + ys;
        r.y   = l.y - xs;
        r.acc = l.acc + ang;
      end else begin
        r.x   = l.x - ys;
        r.y   = l.y + xs;
        r.acc = l.acc - ang;
      end
    end
    return r;
  endfunction

  // One quotient bit of the restoring divide by the rotor maximum.
  function automatic dv_t dv_step(dv_t l);
    logic [ELEV_W:0] cur;
    dv_t             r;
    r   = l;
    cur = {l.rem, l.low[16]};
    if (cur >= {1'b0, l.m}) begin
      r.rem = ELEV_W'(cur - {1'b0, l.m});
      r.quo = {l.quo[15:0], 1'b1};
    end else begin
      r.rem = cur[ELEV_W-1:0];
      r.quo = {l.quo[15:0], 1'b0};
    end
    r.low = {l.low[15:0], 1'b0};
    return r;
  endfunction

endpackage

[rtl/tvta_if.sv]
// Valid/ready stream interfaces for thrust vector words and tilt angle words.
interface tvta_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         rotor_index;
  logic signed [15:0] thrust_x;
  logic signed [15:0] thrust_y;
  logic signed [15:0] thrust_z;
  modport source (output valid, rotor_index, thrust_x, thrust_y, thrust_z, input ready);
  modport sink (input valid, rotor_index, thrust_x, thrust_y, thrust_z, output ready);
endinterface

interface tvta_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         rotor_tag;
  logic [15:0]        thrust_norm;
  logic signed [15:0] elevation_cmd;
  logic signed [15:0] azimuth_cmd;
  modport source (output valid, rotor_tag, thrust_norm, elevation_cmd, azimuth_cmd,
                  input ready);
  modport sink (input valid, rotor_tag, thrust_norm, elevation_cmd, azimuth_cmd,
                output ready);
endinterface

[rtl/thrust_vector_to_tilt_angles.sv]
// Top level: thrust vector to magnitude, azimuth and elevation tilt commands.
// Throughput: one word per cycle; the whole row of cells advances together and stops
//   only while the output register holds a word that is not taken.
// Reset: rst_ni clears the pipeline valid bits and loads 900 into every rotor maximum.
// Depth is set by the 32 square-root cells, the CORDIC cells and the 17 divider cells.
module thrust_vector_to_tilt_angles #(
  parameter int ROTORS        = tvta_pkg::ROTORS_DEF,
  parameter int CORDIC_STAGES = tvta_pkg::STAGES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tvta_pkg::PADDR_W-1:0] paddr,
  input  logic [tvta_pkg::PDATA_W-1:0] pwdata,
  output logic [tvta_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  tvta_in_if.sink                      in_i,
  tvta_out_if.source                   out_o
);

  localparam int SQ = tvta_pkg::SQRT_STEPS;
  localparam int DS = tvta_pkg::DIV_STEPS;
  // input square, sum, sqrt row, prep, cordic row, post, multiply, numerator, div row, out
  localparam int NSTG = 2 + SQ + 1 + CORDIC_STAGES + 3 + DS + 1;

  typedef struct packed {
    logic [31:0]        xx;
    logic [31:0]        yy;
    logic [31:0]        zz;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [1:0]         idx;
  } sqa_t;

  typedef struct packed {
    logic [31:0]        sxy;
    logic [31:0]        s;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [1:0]         idx;
  } sqb_t;

  typedef struct packed {
    logic [15:0]                 az;
    logic [tvta_pkg::EW-1:0]     e;
    logic [tvta_pkg::ELEV_W-1:0] m;
    logic [15:0]                 mag;
    logic [1:0]                  idx;
  } post_t;

  typedef struct packed {
    logic [tvta_pkg::PROD_W-1:0] prod;
    logic [tvta_pkg::ELEV_W-1:0] m;
    logic [15:0]                 az;
    logic [15:0]                 mag;
    logic [1:0]                  idx;
  } mul_t;

  typedef struct packed {
    logic [1:0]  idx;
    logic [15:0] mag;
    logic [15:0] elev;
    logic [15:0] az;
  } res_t;

  // ---------------------------------------------------------------------------
  // Configuration registers: one rotor maximum per word address.
  // ---------------------------------------------------------------------------
  logic [tvta_pkg::ELEV_W-1:0]    cfg_q [tvta_pkg::CFG_REGS];
  logic [tvta_pkg::CFG_IDX_W-1:0] cfg_sel;

  assign cfg_sel = paddr[tvta_pkg::PADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = tvta_pkg::PDATA_W'(cfg_q[cfg_sel]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tvta_pkg::CFG_REGS; i++) begin
        cfg_q[i] <= tvta_pkg::ELEV_RESET;
      end
    end else if (psel && penable && pwrite) begin
      cfg_q[cfg_sel] <= pwdata[tvta_pkg::ELEV_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: every cell advances when the output register is free or drains.
  // ---------------------------------------------------------------------------
  logic            en;
  logic [NSTG-1:0] vld_q;

  assign en         = !vld_q[NSTG-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Squares, then the two radicands.
  // ---------------------------------------------------------------------------
  sqa_t              a_q;
  sqb_t              b_q;
  logic signed [31:0] xe, ye, ze;

  assign xe = 32'(in_i.thrust_x);
  assign ye = 32'(in_i.thrust_y);
  assign ze = 32'(in_i.thrust_z);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q.xx  <= xe * xe;
      a_q.yy  <= ye * ye;
      a_q.zz  <= ze * ze;
      a_q.x   <= in_i.thrust_x;
      a_q.y   <= in_i.thrust_y;
      a_q.z   <= in_i.thrust_z;
      a_q.idx <= in_i.rotor_index;
      b_q.sxy <= a_q.xx + a_q.yy;
      b_q.s   <= a_q.xx + a_q.yy + a_q.zz;
      b_q.x   <= a_q.x;
      b_q.y   <= a_q.y;
      b_q.z   <= a_q.z;
      b_q.idx <= a_q.idx;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root row: magnitude root of s, and root of sxy * 2^32 for elevation.
  // ---------------------------------------------------------------------------
  tvta_pkg::sq_t sq_w [SQ+1];

  always_comb begin
    sq_w[0].m.rem  = '0;
    sq_w[0].m.root = '0;
    sq_w[0].m.rad  = {32'b0, b_q.s};
    sq_w[0].r.rem  = '0;
    sq_w[0].r.root = '0;
    sq_w[0].r.rad  = {b_q.sxy, 32'b0};
    sq_w[0].x      = b_q.x;
    sq_w[0].y      = b_q.y;
    sq_w[0].z      = b_q.z;
    sq_w[0].idx    = b_q.idx;
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    tvta_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (sq_w[k]),
      .q_o   (sq_w[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Round the magnitude and fold both vectors for the CORDIC row.
  // ---------------------------------------------------------------------------
  tvta_pkg::sq_t              sq_f;
  logic signed [tvta_pkg::CW-1:0] ax, ay, ez, er;
  logic [15:0]                mag_rnd;
  tvta_pkg::cd_t              cd_w [CORDIC_STAGES+1];
  tvta_pkg::cd_t              cd_q;

  assign sq_f    = sq_w[SQ];
  assign ax      = {{3{sq_f.x[15]}}, sq_f.x, 16'b0};
  assign ay      = {{3{sq_f.y[15]}}, sq_f.y, 16'b0};
  assign ez      = {{3{sq_f.z[15]}}, sq_f.z, 16'b0};
  assign er      = {3'b000, sq_f.r.root};
  // round to nearest: bump when the remainder exceeds the root
  assign mag_rnd = sq_f.m.root[15:0] + 16'(sq_f.m.rem > {2'b00, sq_f.m.root});

  always_ff @(posedge clk_i) begin
    if (en) begin
      cd_q.az  <= tvta_pkg::cl_pre(ax, ay);
      cd_q.el  <= tvta_pkg::cl_pre(-ez, er);
      cd_q.mag <= mag_rnd;
      cd_q.idx <= sq_f.idx;
    end
  end

  assign cd_w[0] = cd_q;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    tvta_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (cd_w[k]),
      .q_o   (cd_w[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Angles to Q1.15 azimuth and clamped elevation; pick the rotor maximum.
  // ---------------------------------------------------------------------------
  tvta_pkg::cd_t                   cd_f;
  logic signed [tvta_pkg::AW:0]    az_t;
  logic signed [tvta_pkg::AW:0]    az_sh;
  logic [15:0]                     az_q15;
  logic [tvta_pkg::EW-1:0]         e_cl;
  logic [tvta_pkg::CFG_IDX_W-1:0]  rot_sel;
  post_t                           post_q;

  assign cd_f  = cd_w[CORDIC_STAGES];
  assign az_t  = (tvta_pkg::AW+1)'(cd_f.az.acc) + 33'sd16384;
  assign az_sh = az_t >>> 15;

  always_comb begin
    priority if (az_sh > 33'sd32767) begin
      az_q15 = 16'h7FFF;
    end else if (az_sh < -33'sd32768) begin
      az_q15 = 16'h8000;
    end else begin
      az_q15 = az_sh[15:0];
    end
  end

  always_comb begin
    priority if (cd_f.el.acc[tvta_pkg::AW-1]) begin
      e_cl = '0;
    end else if (cd_f.el.acc > tvta_pkg::PI_UNITS) begin
      e_cl = tvta_pkg::PI_UNITS[tvta_pkg::EW-1:0];
    end else begin
      e_cl = cd_f.el.acc[tvta_pkg::EW-1:0];
    end
  end

  // rotor numbers past the last rotor use the last rotor's maximum
  assign rot_sel = (32'(cd_f.idx) < ROTORS) ? cd_f.idx
                                             : tvta_pkg::CFG_IDX_W'(ROTORS - 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      post_q.az  <= az_q15;
      post_q.e   <= e_cl;
      post_q.m   <= cfg_q[rot_sel];
      post_q.mag <= cd_f.mag;
      post_q.idx <= cd_f.idx;
    end
  end

  // ---------------------------------------------------------------------------
  // Scale: e * 1800, then numerator with half-divisor rounding for the divider row.
  // ---------------------------------------------------------------------------
  mul_t                        mul_q;
  logic [tvta_pkg::PROD_W:0]   num;
  tvta_pkg::dv_t               dv_w [DS+1];
  tvta_pkg::dv_t               dv_q;
  logic [tvta_pkg::NUM_W-1:0]  num_sh;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_q.prod <= tvta_pkg::PROD_W'(post_q.e) *
                    tvta_pkg::PROD_W'(tvta_pkg::MaxDeciDeg);
      mul_q.m    <= post_q.m;
      mul_q.az   <= post_q.az;
      mul_q.mag  <= post_q.mag;
      mul_q.idx  <= post_q.idx;
    end
  end

  // dividing by m * 2^14 equals dividing the numerator shifted down 14 by m
  assign num    = (tvta_pkg::PROD_W+1)'(mul_q.prod) +
                  (tvta_pkg::PROD_W+1)'({mul_q.m, 13'b0});
  assign num_sh = num[tvta_pkg::PROD_W:14];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q.rem <= num_sh[tvta_pkg::NUM_W-1:17];
      dv_q.low <= num_sh[16:0];
      dv_q.quo <= '0;
      dv_q.m   <= mul_q.m;
      dv_q.sat <= (mul_q.m == '0) ||
                  (mul_q.prod > tvta_pkg::PROD_W'({mul_q.m, 30'b0}));
      dv_q.az  <= mul_q.az;
      dv_q.mag <= mul_q.mag;
      dv_q.idx <= mul_q.idx;
    end
  end

  assign dv_w[0] = dv_q;

  for (genvar k = 0; k < DS; k++) begin : g_div
    tvta_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (dv_w[k]),
      .q_o   (dv_w[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: offset the quotient by -1 and saturate at +1.
  // ---------------------------------------------------------------------------
  tvta_pkg::dv_t dv_f;
  res_t          res_q;

  assign dv_f = dv_w[DS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q.idx  <= dv_f.idx;
      res_q.mag  <= dv_f.mag;
      res_q.az   <= dv_f.az;
      res_q.elev <= (dv_f.sat || dv_f.quo[16]) ? 16'h7FFF
                                               : {~dv_f.quo[15], dv_f.quo[14:0]};
    end
  end

  assign out_o.valid         = vld_q[NSTG-1];
  assign out_o.rotor_tag     = res_q.idx;
  assign out_o.thrust_norm   = res_q.mag;
  assign out_o.elevation_cmd = res_q.elev;
  assign out_o.azimuth_cmd   = res_q.az;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_stall_freezes_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted word did not enter the first cell");

  a_mag_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.thrust_norm <= 16'd56756))
    else $error("thrust magnitude out of range");

endmodule

[rtl/tvta_sqrt_cell.sv]
// Square root cell: one root digit for both root lanes, payload handed on.
module tvta_sqrt_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  tvta_pkg::sq_t d_i,
  output tvta_pkg::sq_t q_o
);
  tvta_pkg::sq_t q_d;
  tvta_pkg::sq_t q_q;

  always_comb begin
    q_d   = d_i;
    q_d.m = tvta_pkg::sq_step(d_i.m);
    q_d.r = tvta_pkg::sq_step(d_i.r);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;
endmodule

[rtl/tvta_cordic_cell.sv]
// CORDIC cell: one micro-rotation for the azimuth and elevation lanes.
module tvta_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  tvta_pkg::cd_t d_i,
  output tvta_pkg::cd_t q_o
);
  tvta_pkg::cd_t q_d;
  tvta_pkg::cd_t q_q;

  always_comb begin
    q_d    = d_i;
    q_d.az = tvta_pkg::cl_step(d_i.az, STAGE, tvta_pkg::ATAN_TAB[STAGE]);
    q_d.el = tvta_pkg::cl_step(d_i.el, STAGE, tvta_pkg::ATAN_TAB[STAGE]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;
endmodule

[rtl/tvta_div_cell.sv]
// Divider cell: one quotient bit of the elevation scaling.
module tvta_div_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  tvta_pkg::dv_t d_i,
  output tvta_pkg::dv_t q_o
);
  tvta_pkg::dv_t q_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= tvta_pkg::dv_step(d_i);
    end
  end

  assign q_o = q_q;
endmodule

[bench/thrust_vector_to_tilt_angles_test.sv]
// Self-checking bench for the thrust vector to tilt angles pipeline.
`timescale 1ns / 100ps

module thrust_vector_to_tilt_angles_test;

  localparam int ROTOR_COUNT  = 4;
  localparam int NUM_STAGES   = 16;
  localparam int PIPE_LATENCY = 56 + NUM_STAGES;
  localparam int RANDOM_WORDS = 600;
  localparam int LONG_HOLD    = 200;
  localparam longint PI_Q30   = 64'sd1 << 30;

  typedef struct {
    logic [1:0]         rotor;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } thrust_word_t;

  typedef struct {
    logic [1:0]         tag;
    logic [15:0]        mag;
    logic signed [15:0] elev;
    logic signed [15:0] azim;
  } tilt_word_t;

  // Directed row: vector plus an optional typed-in answer.
  typedef struct {
    thrust_word_t stim;
    bit           known;
    tilt_word_t   ans;
  } vec_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [tvta_pkg::PADDR_W-1:0] paddr = '0;
  logic [tvta_pkg::PDATA_W-1:0] pwdata = '0;
  logic [tvta_pkg::PDATA_W-1:0] prdata;
  logic pready;

  tvta_in_if  thrust_ch ();
  tvta_out_if tilt_ch ();

  thrust_vector_to_tilt_angles #(.ROTORS(ROTOR_COUNT), .CORDIC_STAGES(NUM_STAGES)) uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_i(thrust_ch.sink), .out_o(tilt_ch.source)
  );

  // Bench copy of the rotor limits and the queue of pending tilt words.
  logic [10:0] elev_limit [ROTOR_COUNT];
  tilt_word_t  tilt_pending [$];
  int          mismatches = 0;
  bit          stall_long = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Floor shift for negative values.
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC angle, pi = 2^30.
  function automatic longint vector_angle(longint x, longint y);
    longint base, acc, xs, ys;
    base = 0;
    acc = 0;
    if (y == 0) return (x < 0) ? PI_Q30 : 0;
    if (x < 0) begin
      base = (y > 0) ? PI_Q30 : -PI_Q30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x += ys;
        y -= xs;
        acc += longint'(tvta_pkg::ATAN_TAB[i]);
      end else begin
        x -= ys;
        y += xs;
        acc -= longint'(tvta_pkg::ATAN_TAB[i]);
      end
    end
    return base + acc;
  endfunction

  function automatic tilt_word_t tilt_from_thrust(thrust_word_t w);
    tilt_word_t r;
    longint x, y, z, e, q, cmd;
    longint unsigned sxy, s, mag, m, den;
    x = w.x;
    y = w.y;
    z = w.z;
    sxy = x * x + y * y;
    s = sxy + z * z;
    mag = int_sqrt(s);
    if (s - mag * mag > mag) mag++;
    q = shr_floor(vector_angle(x * 65536, y * 65536) + (64'sd1 << 14), 15);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    e = vector_angle(-z * 65536, longint'(int_sqrt(sxy << 32)));
    if (e < 0) e = 0;
    if (e > PI_Q30) e = PI_Q30;
    m = elev_limit[(w.rotor < ROTOR_COUNT) ? w.rotor : ROTOR_COUNT - 1];
    if (m == 0 || longint'(e) * 1800 > longint'(m << 30)) begin
      cmd = 32767;
    end else begin
      den = m << 14;
      cmd = longint'((longint'(e) * 1800 + (den >> 1)) / den) - 32768;
      if (cmd > 32767) cmd = 32767;
    end
    r.tag = w.rotor;
    r.mag = mag[15:0];
    r.elev = cmd[15:0];
    r.azim = q[15:0];
    return r;
  endfunction

  // Single APB write: setup then access phase, changed on falling edges.
  task automatic write_limit(int idx, logic [10:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= tvta_pkg::PADDR_W'(idx * 4);
    pwdata <= tvta_pkg::PDATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    elev_limit[idx] = val;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until the pipe has drained.
  task automatic drain_pipe();
    while (tilt_pending.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic offer_word(thrust_word_t w, bit check_known, tilt_word_t ans);
    @(negedge clk_i);
    thrust_ch.valid <= 1'b1;
    thrust_ch.rotor_index <= w.rotor;
    thrust_ch.thrust_x <= w.x;
    thrust_ch.thrust_y <= w.y;
    thrust_ch.thrust_z <= w.z;
    @(posedge clk_i);
    while (!thrust_ch.ready) @(posedge clk_i);
    tilt_pending.push_back(check_known ? ans : tilt_from_thrust(w));
  endtask

  task automatic idle_sender(int n);
    @(negedge clk_i);
    thrust_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic thrust_word_t rand_thrust();
    thrust_word_t w;
    int mode;
    w.rotor = 2'($urandom_range(0, 3));
    mode = $urandom_range(0, 9);
    w.x = 16'($urandom);
    w.y = 16'($urandom);
    w.z = 16'($urandom);
    // Push some words onto the axes and to small sizes to hit exact angles.
    if (mode == 0) w.y = 0;
    if (mode == 1) w.x = 0;
    if (mode == 2) begin
      w.x = 0;
      w.y = 0;
    end
    if (mode == 3) begin
      w.x = 16'(int'($urandom_range(0, 15)) - 8);
      w.y = 16'(int'($urandom_range(0, 15)) - 8);
    end
    return w;
  endfunction

  // Directed table; answers typed in only where they are plain.
  function automatic vec_row_t mk_row(logic [1:0] r, int x, int y, int z, bit k,
                                      int mag, int el, int az);
    vec_row_t row;
    row.stim = '{rotor: r, x: 16'(x), y: 16'(y), z: 16'(z)};
    row.known = k;
    row.ans = '{tag: r, mag: 16'(mag), elev: 16'(el), azim: 16'(az)};
    return row;
  endfunction

  task automatic run_directed();
    vec_row_t rows [$];
    tilt_word_t none;
    none = '{default: '0};
    rows.push_back(mk_row(0, 0, 0, 0, 1, 0, -32768, 0));
    rows.push_back(mk_row(1, 0, 0, 100, 1, 100, 32767, 0));
    rows.push_back(mk_row(2, 0, 0, -100, 1, 100, -32768, 0));
    rows.push_back(mk_row(3, 32767, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(0, -32768, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(1, 0, 32767, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(2, 0, -32768, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(3, -32768, -32768, -32768, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 32767, 32767, 32767, 0, 0, 0, 0));
    rows.push_back(mk_row(1, -32768, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(2, -32768, -1, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(3, 1, 1, -1, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 100, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(1, -5, 7, 3, 0, 0, 0, 0));
    rows.push_back(mk_row(2, 12345, -23456, 4321, 0, 0, 0, 0));
    rows.push_back(mk_row(3, 21845, -21846, 10923, 0, 0, 0, 0));
    foreach (rows[i]) offer_word(rows[i].stim, rows[i].known, rows[i].known ? rows[i].ans : none);
    idle_sender(1);
  endtask

  task automatic run_random(int count);
    int left, burst;
    tilt_word_t none;
    none = '{default: '0};
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && left > 0; b++, left--) offer_word(rand_thrust(), 0, none);
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end
    idle_sender(1);
  endtask

  // Stimulus and register phases.
  initial begin
    thrust_ch.valid = 1'b0;
    thrust_ch.rotor_index = '0;
    thrust_ch.thrust_x = '0;
    thrust_ch.thrust_y = '0;
    thrust_ch.thrust_z = '0;
    for (int i = 0; i < ROTOR_COUNT; i++) elev_limit[i] = 11'd900;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    drain_pipe();
    // Limits at the extremes: smallest, zero, largest field value, 180 degrees.
    write_limit(0, 11'd1);
    write_limit(1, 11'd0);
    write_limit(2, 11'd2047);
    write_limit(3, 11'd1800);
    run_directed();
    // Hold the receiver off while offering words so the pipe fills up.
    stall_long = 1'b1;
    run_random(RANDOM_WORDS / 4);
    drain_pipe();
    for (int i = 0; i < ROTOR_COUNT; i++) write_limit(i, 11'($urandom_range(1, 1800)));
    run_random(RANDOM_WORDS * 3 / 8);
    drain_pipe();
    for (int i = 0; i < ROTOR_COUNT; i++) write_limit(i, 11'($urandom_range(0, 2047)));
    run_random(RANDOM_WORDS * 3 / 8);
    drain_pipe();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: own stall pattern plus one long hold-off when asked.
  initial begin
    int phase;
    phase = 0;
    tilt_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_long) begin
        stall_long = 1'b0;
        tilt_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      phase++;
      if ((phase / 64) % 3 == 2) tilt_ch.ready <= 1'b1;
      else tilt_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each accepted tilt word with the oldest pending one.
  always @(posedge clk_i) begin
    tilt_word_t exp_w;
    if (rst_ni && tilt_ch.valid && tilt_ch.ready) begin
      if (tilt_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tilt word tag %0d", tilt_ch.rotor_tag);
      end else begin
        exp_w = tilt_pending.pop_front();
        if (tilt_ch.rotor_tag !== exp_w.tag || tilt_ch.thrust_norm !== exp_w.mag ||
            tilt_ch.elevation_cmd !== exp_w.elev || tilt_ch.azimuth_cmd !== exp_w.azim) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp tag %0d mag %0d el %0d az %0d got %0d %0d %0d %0d",
                     exp_w.tag, exp_w.mag, exp_w.elev, exp_w.azim, tilt_ch.rotor_tag,
                     tilt_ch.thrust_norm, tilt_ch.elevation_cmd, tilt_ch.azimuth_cmd);
        end
      end
    end
  end

endmodule
